// File: hdl/tpe_pkg.sv
// shared types and widths for the triangle plane equation pipeline
package tpe_pkg;

    // coordinate, edge, product and cross product widths
    localparam int CW    = 32;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int XW    = PW + 1;
    localparam int MAGW  = PW;
    // reduced mantissa, sum of squares and length widths
    localparam int MW      = 31;
    localparam int SSW     = 64;
    localparam int LW      = 32;
    localparam int RED_TOP = MW - 1;
    localparam int TOPW    = 7;

    typedef logic [2:0][CW-1:0]   vec3_t;
    typedef logic [2:0][MAGW-1:0] mag3_t;
    typedef logic [2:0][MW-1:0]   m3_t;

    // side band that travels alongside the length and division stages
    typedef struct packed {
        m3_t        m;
        logic [2:0] neg;
        logic       deg;
        vec3_t      a;
    } tpe_side_t;

endpackage

// File: hdl/triangle_plane_equation.sv
// Triangle plane equation: unit normal and offset from three vertices.
//
// A transfer is taken at every rising edge with start high and busy low;
// busy stays low, so a new triangle may be started in every cycle.
// Inputs are three vertices a, b, c in signed Q16.16. The result is the
// unit normal of (c - a) x (b - a) in Q1.30 and offset_d = -dot(a, n)
// in Q16.16, rounded half away from zero and saturated.
// A zero cross product sets degenerate, with normal and offset zero.
// The pipeline has three cross product stages, four reduction stages,
// 32 square root stages, one numerator stage, NORMAL_FRAC_BITS + 1
// divider stages and three offset stages. Throughput is one triangle
// per clock.
// done is high for exactly one cycle with each result; the receiver
// cannot hold results off and none is needed.
// Reset clears all valid bits; triangles in flight are dropped.
module triangle_plane_equation
    import tpe_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               done,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic signed [31:0] offset_d,
    output logic               degenerate
);

    localparam int NFB  = NORMAL_FRAC_BITS;
    localparam int QW   = NFB + 1;
    localparam int NW   = NFB + MW + 1;
    localparam int NSW  = QW + 1;
    localparam int DPW  = CW + NSW;
    localparam int SW   = DPW + 2;
    localparam int SBW  = $bits(tpe_side_t);
    localparam int LAT  = 44 + NFB;
    localparam logic [SW-1:0] HALF    = SW'(1) << (NFB - 1);
    localparam logic [SW-1:0] NEG_LIM = SW'(64'h8000_0000);
    localparam logic [SW-1:0] POS_LIM = SW'(64'h7fff_ffff);

    vec3_t            va, vb, vc, cr_a;
    mag3_t            cr_mag;
    logic [2:0]       cr_neg;
    logic             cr_v, nm_v, sq_v;
    tpe_side_t        nm_side, sq_side;
    logic [SBW-1:0]   sq_side_bits;
    logic [SSW-1:0]   nm_sumsq;
    logic [LW-1:0]    root;

    logic             pv_reg;
    tpe_side_t        ps_reg;
    logic [NW-1:0]    num_reg [3];
    logic [NW-1:0]    num_next [3];
    logic [LW-1:0]    den_reg;
    logic [QW-1:0]    quo [3];

    logic             dl_v_reg [QW];
    tpe_side_t        dl_s_reg [QW];
    tpe_side_t        dv_side;

    logic signed [NSW-1:0] n_next [3];
    logic signed [NSW-1:0] n1_reg [3];
    logic signed [NSW-1:0] n2_reg [3];
    logic signed [DPW-1:0] prod_reg [3];
    logic signed [DPW-1:0] prod_next [3];
    logic                  v1_reg, v2_reg;
    logic                  deg1_reg, deg2_reg;
    logic signed [SW-1:0]  psum_reg, psum_next;

    logic                  dneg;
    logic [SW-1:0]         pmag, mg;
    logic signed [31:0]    d_next;

    logic                  done_reg;
    logic signed [31:0]    nx_reg, ny_reg, nz_reg, d_reg;
    logic                  deg_reg;

    assign busy = 1'b0;
    assign va   = {a_z, a_y, a_x};
    assign vb   = {b_z, b_y, b_x};
    assign vc   = {c_z, c_y, c_x};

    tpe_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .a         (va),
        .b         (vb),
        .c         (vc),
        .out_valid (cr_v),
        .mag       (cr_mag),
        .neg       (cr_neg),
        .a_out     (cr_a)
    );

    tpe_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_v),
        .mag       (cr_mag),
        .neg       (cr_neg),
        .a         (cr_a),
        .out_valid (nm_v),
        .side      (nm_side),
        .sumsq     (nm_sumsq)
    );

    tpe_sqrt #(
        .SBW (SBW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nm_v),
        .rad       (nm_sumsq),
        .side_in   (nm_side),
        .out_valid (sq_v),
        .root      (root),
        .side_out  (sq_side_bits)
    );

    assign sq_side = tpe_side_t'(sq_side_bits);

    // rounded numerators m * 2^NFB + floor(len / 2)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num_next[i] = (NW'(sq_side.m[i]) << NFB) + NW'(root >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= sq_v;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= root;
        ps_reg  <= sq_side;
    end

    // one divider per normal component
    for (genvar i = 0; i < 3; i++)
    begin : g_div
        tpe_div #(
            .QW (QW),
            .NW (NW)
        ) u_div (
            .clk (clk),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    // side band delay matching the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                dl_v_reg[k] <= 1'b0;
        end
        else
        begin
            dl_v_reg[0] <= pv_reg;
            for (int k = 1; k < QW; k++)
                dl_v_reg[k] <= dl_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dl_s_reg[0] <= ps_reg;
        for (int k = 1; k < QW; k++)
            dl_s_reg[k] <= dl_s_reg[k-1];
    end

    assign dv_side = dl_s_reg[QW-1];

    // signed normal and its products with the first vertex
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side.deg)
                n_next[i] = '0;
            else if (dv_side.neg[i])
                n_next[i] = -$signed(NSW'(quo[i]));
            else
                n_next[i] = $signed(NSW'(quo[i]));
            prod_next[i] = DPW'($signed(dv_side.a[i])) * DPW'(n_next[i]);
        end
    end

    // dot product sum
    assign psum_next = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);

    // negate, round half away from zero, saturate
    always_comb
    begin
        dneg = (psum_reg > 0);
        pmag = psum_reg[SW-1] ? SW'(-psum_reg) : SW'(psum_reg);
        mg   = (pmag + HALF) >> NFB;
        if (dneg)
            d_next = (mg > NEG_LIM) ? 32'sh8000_0000 : 32'(SW'(0) - mg);
        else
            d_next = (mg > POS_LIM) ? 32'sh7fff_ffff : 32'(mg);
    end

    // valid bits of the offset stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= dl_v_reg[QW-1];
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // offset data stages and result registers
    always_ff @(posedge clk)
    begin
        n1_reg   <= n_next;
        prod_reg <= prod_next;
        deg1_reg <= dv_side.deg;
        n2_reg   <= n1_reg;
        psum_reg <= psum_next;
        deg2_reg <= deg1_reg;
        nx_reg   <= 32'(n2_reg[0]);
        ny_reg   <= 32'(n2_reg[1]);
        nz_reg   <= 32'(n2_reg[2]);
        d_reg    <= d_next;
        deg_reg  <= deg2_reg;
    end

    assign done       = done_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign offset_d   = d_reg;
    assign degenerate = deg_reg;

`ifndef SYNTHESIS
    localparam logic signed [31:0] NMAX = 32'(64'd1 << NFB);

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
            && offset_d == 0)
        else $error("degenerate result with non-zero plane");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> normal_x <= NMAX && normal_x >= -NMAX
            && normal_y <= NMAX && normal_y >= -NMAX
            && normal_z <= NMAX && normal_z >= -NMAX)
        else $error("normal component out of range");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching start transfer");
`endif

endmodule

// File: hdl/tpe_cross.sv
// edge vectors, partial products and cross product magnitudes
module tpe_cross
    import tpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  vec3_t      a,
    input  vec3_t      b,
    input  vec3_t      c,
    output logic       out_valid,
    output mag3_t      mag,
    output logic [2:0] neg,
    output vec3_t      a_out
);

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [EW-1:0]  e1_next [3];
    logic signed [EW-1:0]  e2_next [3];
    logic signed [PW-1:0]  prod_reg [6];
    logic signed [PW-1:0]  prod_next [6];
    logic signed [XW-1:0]  cr [3];
    mag3_t                 mag_reg, mag_next;
    logic [2:0]            neg_reg, neg_next;
    vec3_t                 a1_reg, a2_reg, a3_reg;

    // edges c - a and b - a, exact in 33 bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i] = $signed({c[i][CW-1], c[i]}) - $signed({a[i][CW-1], a[i]});
            e2_next[i] = $signed({b[i][CW-1], b[i]}) - $signed({a[i][CW-1], a[i]});
        end
    end

    // six partial products of the cross product
    always_comb
    begin
        prod_next[0] = PW'(e1_reg[1]) * PW'(e2_reg[2]);
        prod_next[1] = PW'(e1_reg[2]) * PW'(e2_reg[1]);
        prod_next[2] = PW'(e1_reg[2]) * PW'(e2_reg[0]);
        prod_next[3] = PW'(e1_reg[0]) * PW'(e2_reg[2]);
        prod_next[4] = PW'(e1_reg[0]) * PW'(e2_reg[1]);
        prod_next[5] = PW'(e1_reg[1]) * PW'(e2_reg[0]);
    end

    // differences, sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr[i]       = XW'(prod_reg[2*i]) - XW'(prod_reg[2*i+1]);
            neg_next[i] = cr[i][XW-1];
            mag_next[i] = neg_next[i] ? MAGW'(-cr[i]) : MAGW'(cr[i]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        a1_reg   <= a;
        prod_reg <= prod_next;
        a2_reg   <= a1_reg;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        a3_reg   <= a2_reg;
    end

    assign out_valid = v3_reg;
    assign mag       = mag_reg;
    assign neg       = neg_reg;
    assign a_out     = a3_reg;

endmodule

// File: hdl/tpe_norm.sv
// mantissa reduction and sum of squares
module tpe_norm
    import tpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mag3_t            mag,
    input  logic [2:0]       neg,
    input  vec3_t            a,
    output logic             out_valid,
    output tpe_side_t        side,
    output logic [SSW-1:0]   sumsq
);

    logic                  v4_reg, v5_reg, v6_reg, v7_reg;
    logic [MAGW-1:0]       orv;
    logic [TOPW-1:0]       top;
    logic [TOPW-1:0]       sh_reg, sh_next;
    logic                  deg_next;
    mag3_t                 mag4_reg;
    logic [2:0]            neg4_reg;
    logic                  deg4_reg;
    vec3_t                 a4_reg;
    tpe_side_t             s5_reg, s5_next, s6_reg, s7_reg;
    logic [2*MW-1:0]       sq_reg [3];
    logic [2*MW-1:0]       sq_next [3];
    logic [SSW-1:0]        sumsq_reg, sumsq_next;

    // highest set bit over the three magnitudes
    always_comb
    begin
        orv = mag[0] | mag[1] | mag[2];
        top = '0;
        for (int i = 0; i < MAGW; i++)
        begin
            if (orv[i])
                top = TOPW'(i);
        end
        deg_next = (orv == '0);
        sh_next  = (top > TOPW'(RED_TOP)) ? top - TOPW'(RED_TOP) : '0;
    end

    // shift down to 31 bit mantissas
    always_comb
    begin
        s5_next     = '0;
        s5_next.neg = neg4_reg;
        s5_next.deg = deg4_reg;
        s5_next.a   = a4_reg;
        for (int i = 0; i < 3; i++)
            s5_next.m[i] = MW'(mag4_reg[i] >> sh_reg);
    end

    // squares and their sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = (2*MW)'(s5_reg.m[i]) * (2*MW)'(s5_reg.m[i]);
        sumsq_next = SSW'(sq_reg[0]) + SSW'(sq_reg[1]) + SSW'(sq_reg[2]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        mag4_reg  <= mag;
        neg4_reg  <= neg;
        deg4_reg  <= deg_next;
        a4_reg    <= a;
        s5_reg    <= s5_next;
        sq_reg    <= sq_next;
        s6_reg    <= s5_reg;
        sumsq_reg <= sumsq_next;
        s7_reg    <= s6_reg;
    end

    assign out_valid = v7_reg;
    assign side      = s7_reg;
    assign sumsq     = sumsq_reg;

endmodule

// File: hdl/tpe_sqrt.sv
// pipelined floor square root, one result bit per stage
module tpe_sqrt
    import tpe_pkg::*;
#(
    parameter int SBW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [SSW-1:0]   rad,
    input  logic [SBW-1:0]   side_in,
    output logic             out_valid,
    output logic [LW-1:0]    root,
    output logic [SBW-1:0]   side_out
);

    logic [SSW-1:0] x_s   [LW+1];
    logic [SSW-1:0] res_s [LW+1];
    logic [SBW-1:0] sb_s  [LW+1];
    logic           v_s   [LW+1];

    assign x_s[0]   = rad;
    assign res_s[0] = '0;
    assign sb_s[0]  = side_in;
    assign v_s[0]   = in_valid;

    for (genvar k = 0; k < LW; k++)
    begin : g_stage
        localparam logic [SSW-1:0] BIT = SSW'(1) << (SSW - 2 - 2 * k);
        logic [SSW-1:0] trial;
        logic [SSW-1:0] x_reg, x_next, res_reg, res_next;
        logic [SBW-1:0] sb_reg;
        logic           v_reg;

        // trial subtraction of this result bit
        always_comb
        begin
            trial = res_s[k] + BIT;
            if (x_s[k] >= trial)
            begin
                x_next   = x_s[k] - trial;
                res_next = (res_s[k] >> 1) + BIT;
            end
            else
            begin
                x_next   = x_s[k];
                res_next = res_s[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= v_s[k];
        end

        always_ff @(posedge clk)
        begin
            x_reg   <= x_next;
            res_reg <= res_next;
            sb_reg  <= sb_s[k];
        end

        assign x_s[k+1]   = x_reg;
        assign res_s[k+1] = res_reg;
        assign sb_s[k+1]  = sb_reg;
        assign v_s[k+1]   = v_reg;
    end

    assign out_valid = v_s[LW];
    assign root      = res_s[LW][LW-1:0];
    assign side_out  = sb_s[LW];

endmodule

// File: hdl/tpe_div.sv
// pipelined restoring divider, one quotient bit per stage
module tpe_div
    import tpe_pkg::*;
#(
    parameter int QW = 31,
    parameter int NW = QW + MW
)
(
    input  logic            clk,
    input  logic [NW-1:0]   num,
    input  logic [LW-1:0]   den,
    output logic [QW-1:0]   quo
);

    logic [LW-1:0] rem_s [QW+1];
    logic [QW-1:0] nb_s  [QW+1];
    logic [QW-1:0] q_s   [QW+1];
    logic [LW-1:0] den_s [QW+1];

    // high part of the numerator is below the divisor
    assign rem_s[0] = LW'(num[NW-1:QW]);
    assign nb_s[0]  = num[QW-1:0];
    assign q_s[0]   = '0;
    assign den_s[0] = den;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [LW:0]   t;
        logic          ge;
        logic [LW-1:0] rem_reg, rem_next, den_reg;
        logic [QW-1:0] nb_reg, q_reg, q_next;

        // bring down one bit and subtract where it fits
        always_comb
        begin
            t        = {rem_s[k], nb_s[k][QW-1]};
            ge       = (t >= {1'b0, den_s[k]});
            rem_next = ge ? LW'(t - {1'b0, den_s[k]}) : LW'(t);
            q_next   = {q_s[k][QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg <= rem_next;
            nb_reg  <= nb_s[k] << 1;
            q_reg   <= q_next;
            den_reg <= den_s[k];
        end

        assign rem_s[k+1] = rem_reg;
        assign nb_s[k+1]  = nb_reg;
        assign q_s[k+1]   = q_reg;
        assign den_s[k+1] = den_reg;
    end

    assign quo = q_s[QW];

endmodule
